// File: src/shabc_pkg.sv
// Shared types, constants and functions for the SHA-256 block compression unit.
// Holds the round constants, sigma functions, sequencer state and control struct.
// No dependencies.
package shabc_pkg;

    localparam int WORD_W      = 32;
    localparam int HASH_WORDS  = 8;
    localparam int HIDX_W      = 3;
    localparam int BLOCK_WORDS = 16;
    localparam int ROUNDS      = 64;
    localparam int RIDX_W      = 6;
    localparam int SCHED_TAP_A = 9;
    localparam int SCHED_TAP_B = 14;

    // Input command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_MSG  = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word [HASH_WORDS-1:0] t_vars;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ACCUM,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic              load_h;
        logic              first_word;
        logic              msg_round;
        logic              exp_round;
        logic              accum;
        logic [RIDX_W-1:0] round_idx;
        logic [HIDX_W-1:0] out_idx;
    } t_ctrl;

    function automatic t_word rotr(t_word x, int unsigned n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word small_s0(t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_s1(t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word big_s0(t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_s1(t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word round_k(logic [RIDX_W-1:0] idx);
        t_word k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = '0;
        endcase
        return k;
    endfunction

endpackage

// File: src/shabc_in_if.sv
// Input channel of the SHA-256 compression unit: valid/ready plus one input word.
// Depends on shabc_pkg.
interface shabc_in_if;
    import shabc_pkg::*;

    logic              valid;
    logic              ready;
    logic              cmd;
    t_word             data_word;
    logic [HIDX_W-1:0] chain_index;

    modport source (output valid, output cmd, output data_word, output chain_index,
                    input ready);
    modport sink   (input valid, input cmd, input data_word, input chain_index,
                    output ready);
endinterface

// File: src/shabc_out_if.sv
// Output channel of the SHA-256 compression unit: valid/ready plus one hash word.
// Depends on shabc_pkg.
interface shabc_out_if;
    import shabc_pkg::*;

    logic              valid;
    logic              ready;
    t_word             hash_word;
    logic [HIDX_W-1:0] hash_index;
    logic              last_word;

    modport source (output valid, output hash_word, output hash_index, output last_word,
                    input ready);
    modport sink   (input valid, input hash_word, input hash_index, input last_word,
                    output ready);
endinterface

// File: src/shabc_round.sv
// Shared SHA-256 round unit: one compression round over the working variables a..h.
// Depends on shabc_pkg.
module shabc_round (
    input  shabc_pkg::t_vars i_v,
    input  shabc_pkg::t_word i_w,
    input  shabc_pkg::t_word i_k,
    output shabc_pkg::t_vars o_v
);
    import shabc_pkg::*;

    t_word w_ch;
    t_word w_maj;
    t_word w_t1;
    t_word w_t2;

    // Form the two temporaries from a..h
    always_comb begin
        w_ch  = (i_v[4] & i_v[5]) ^ (~i_v[4] & i_v[6]);
        w_maj = (i_v[0] & i_v[1]) ^ (i_v[0] & i_v[2]) ^ (i_v[1] & i_v[2]);
        w_t1  = i_v[7] + big_s1(i_v[4]) + w_ch + i_k + i_w;
        w_t2  = big_s0(i_v[0]) + w_maj;
    end

    // Rotate the variables and insert the new a and e
    always_comb begin
        o_v[7] = i_v[6];
        o_v[6] = i_v[5];
        o_v[5] = i_v[4];
        o_v[4] = i_v[3] + w_t1;
        o_v[3] = i_v[2];
        o_v[2] = i_v[1];
        o_v[1] = i_v[0];
        o_v[0] = w_t1 + w_t2;
    end

endmodule

// File: src/shabc_sched.sv
// Message schedule: 16-word rolling window with a registered expansion word.
// Depends on shabc_pkg.
module shabc_sched (
    input  logic             i_clk,
    input  shabc_pkg::t_ctrl i_ctrl,
    input  shabc_pkg::t_word i_msg_word,
    output shabc_pkg::t_word o_w
);
    import shabc_pkg::*;

    // The next word is registered ahead of its round, from the window before the current word shifts in,
    // so every tap sits one place higher than in the plain recurrence.
    localparam int TAP_OLD = 1;
    localparam int TAP_S0  = 2;
    localparam int TAP_A   = SCHED_TAP_A + 1;
    localparam int TAP_S1  = SCHED_TAP_B + 1;

    t_word r_win [BLOCK_WORDS];
    t_word r_w_pre;

    // Pick the word for the current round
    assign o_w = i_ctrl.msg_round ? i_msg_word : r_w_pre;

    // Shift the window on every round
    always_ff @(posedge i_clk) begin
        if (i_ctrl.msg_round || i_ctrl.exp_round) begin
            for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[BLOCK_WORDS-1] <= o_w;
        end
    end

    // Precompute the next expanded word
    always_ff @(posedge i_clk) begin
        r_w_pre <= r_win[TAP_OLD] + small_s0(r_win[TAP_S0]) + small_s1(r_win[TAP_S1])
                   + r_win[TAP_A];
    end

endmodule

// File: src/shabc_ctrl.sv
// Sequencer of the SHA-256 compression unit: round counter, output counter and FSM.
// Depends on shabc_pkg.
module shabc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_cmd,
    input  logic             i_out_ready,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output shabc_pkg::t_ctrl o_ctrl
);
    import shabc_pkg::*;

    localparam logic [RIDX_W-1:0] LAST_MSG   = RIDX_W'(BLOCK_WORDS - 1);
    localparam logic [RIDX_W-1:0] LAST_ROUND = RIDX_W'(ROUNDS - 1);
    localparam logic [HIDX_W-1:0] LAST_OUT   = HIDX_W'(HASH_WORDS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [RIDX_W-1:0] r_round;
    logic [RIDX_W-1:0] n_round;
    logic [HIDX_W-1:0] r_out_cnt;
    logic [HIDX_W-1:0] n_out_cnt;
    logic              w_accept;
    logic              w_msg;

    assign w_accept = i_in_valid && o_in_ready;
    assign w_msg    = w_accept && (i_in_cmd == CMD_MSG);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_msg && (r_round == LAST_MSG)) n_state = ST_EXPAND;
            end
            ST_EXPAND: begin
                if (r_round == LAST_ROUND) n_state = ST_ACCUM;
            end
            ST_ACCUM: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_out_ready && (r_out_cnt == LAST_OUT)) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_ctrl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
            end
            ST_EXPAND: begin
                o_ctrl.exp_round = 1'b1;
            end
            ST_ACCUM: begin
                o_ctrl.accum = 1'b1;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
        o_ctrl.load_h     = w_accept && (i_in_cmd == CMD_LOAD);
        o_ctrl.msg_round  = w_msg;
        o_ctrl.first_word = w_msg && (r_round == '0);
        o_ctrl.round_idx  = r_round;
        o_ctrl.out_idx    = r_out_cnt;
    end

    // Advance the counters
    always_comb begin
        n_round   = r_round;
        n_out_cnt = r_out_cnt;
        if (w_msg || (r_state == ST_EXPAND)) n_round = r_round + 1'b1;
        if ((r_state == ST_EMIT) && i_out_ready) n_out_cnt = r_out_cnt + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_round   <= '0;
            r_out_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_round   <= n_round;
            r_out_cnt <= n_out_cnt;
        end
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while output word pending");

    a_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_msg && (r_round == LAST_MSG)) |=> (r_state == ST_EXPAND))
        else $error("sixteenth word did not start expansion");

    a_emit_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_round == '0))
        else $error("round counter not wrapped during output");

    a_accum_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACCUM) |=> ((r_state == ST_EMIT) && (r_out_cnt == '0)))
        else $error("output did not start at word zero");

endmodule

// File: src/sha256_block_compress_unit.sv
// Top level of the SHA-256 block compression unit: chaining and working registers.
// Depends on shabc_pkg, shabc_in_if, shabc_out_if, shabc_ctrl, shabc_sched, shabc_round.
//
// A load word writes one chaining word H0..H7. Each message word runs one
// round in the cycle it is accepted; the first word of a block starts from the current
// chaining value. The sixteenth word then keeps the block busy for 48 more rounds
// (one per cycle in the single shared round unit), an accumulate step to add the working
// variables into the chaining value, and eight output words, H0 first, the last one
// flagged, one per cycle while the sink is ready. Input is not taken until the
// eighth hash word has gone out.
module sha256_block_compress_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    shabc_in_if.sink           i_in_ch,
    shabc_out_if.source        o_out_ch
);
    import shabc_pkg::*;

    t_ctrl w_ctrl;
    t_vars r_hash;
    t_vars r_vars;
    t_vars w_round_in;
    t_vars w_round_out;
    t_word w_sched_w;
    t_word w_k;

    shabc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_ch.valid),
        .i_in_cmd    (i_in_ch.cmd),
        .i_out_ready (o_out_ch.ready),
        .o_in_ready  (i_in_ch.ready),
        .o_out_valid (o_out_ch.valid),
        .o_ctrl      (w_ctrl)
    );

    shabc_sched u_sched (
        .i_clk      (i_clk),
        .i_ctrl     (w_ctrl),
        .i_msg_word (i_in_ch.data_word),
        .o_w        (w_sched_w)
    );

    // Start a block from the chaining value
    assign w_round_in = w_ctrl.first_word ? r_hash : r_vars;
    assign w_k        = round_k(w_ctrl.round_idx);

    shabc_round u_round (
        .i_v (w_round_in),
        .i_w (w_sched_w),
        .i_k (w_k),
        .o_v (w_round_out)
    );

    // Hold chaining and working variables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_vars <= '0;
        end else begin
            if (w_ctrl.load_h) begin
                r_hash[i_in_ch.chain_index] <= i_in_ch.data_word;
            end else if (w_ctrl.accum) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    r_hash[i] <= r_hash[i] + r_vars[i];
                end
            end
            if (w_ctrl.msg_round || w_ctrl.exp_round) begin
                r_vars <= w_round_out;
            end
        end
    end

    // Drive the output word
    assign o_out_ch.hash_word  = r_hash[w_ctrl.out_idx];
    assign o_out_ch.hash_index = w_ctrl.out_idx;
    assign o_out_ch.last_word  = (w_ctrl.out_idx == HIDX_W'(HASH_WORDS - 1));

endmodule

// File: verif/sha256_block_compress_checker.sv
// Checker for the SHA-256 block compression unit: watches both channels, predicts hash words.
// Depends on shabc_pkg, shabc_in_if and shabc_out_if.
module sha256_block_compress_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    shabc_in_if   i_in_ch,
    shabc_out_if  i_out_ch,
    output int    o_mismatch_count,
    output int    o_pending_words
);
    import shabc_pkg::*;

    typedef struct packed {
        t_word             word;
        logic [HIDX_W-1:0] index;
        logic              last;
    } t_hash_expect;

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Predicted block state
    t_word        chain_h [HASH_WORDS];
    t_word        work_v  [HASH_WORDS];
    t_word        sched_w [BLOCK_WORDS];
    logic [3:0]   msg_count;
    t_hash_expect expected_hash_q [$];

    function automatic t_word ror32(t_word x, int n);
        logic [2*WORD_W-1:0] dbl;
        dbl = {x, x};
        return dbl[n +: WORD_W];
    endfunction

    function automatic t_word sig_lo0(t_word x);
        return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word sig_lo1(t_word x);
        return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word sig_up0(t_word x);
        return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
    endfunction

    function automatic t_word sig_up1(t_word x);
        return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
    endfunction

    // One compression round on the working variables a..h
    task automatic step_work_vars(t_word w, t_word k);
        t_word t1;
        t_word t2;
        t_word choose;
        t_word major;
        choose = (work_v[4] & work_v[5]) ^ (~work_v[4] & work_v[6]);
        major  = (work_v[0] & work_v[1]) ^ (work_v[0] & work_v[2]) ^ (work_v[1] & work_v[2]);
        t1 = work_v[7] + sig_up1(work_v[4]) + choose + k + w;
        t2 = sig_up0(work_v[0]) + major;
        for (int i = HASH_WORDS - 1; i > 0; i--) begin
            work_v[i] = work_v[i-1];
        end
        work_v[4] = work_v[4] + t1;
        work_v[0] = t1 + t2;
    endtask

    // Apply one accepted input word; the sixteenth message word queues eight hash words
    task automatic absorb_sha_word(logic cmd, t_word data, logic [HIDX_W-1:0] idx);
        t_word        slot;
        t_hash_expect hx;
        if (cmd == CMD_LOAD) begin
            chain_h[idx] = data;
        end else begin
            if (msg_count == 4'd0) begin
                work_v = chain_h;
            end
            sched_w[msg_count] = data;
            step_work_vars(data, ROUND_K[msg_count]);
            if (msg_count != 4'd15) begin
                msg_count = msg_count + 4'd1;
            end else begin
                msg_count = 4'd0;
                // Rolling 16-word message schedule for rounds 16..63
                for (int r = BLOCK_WORDS; r < ROUNDS; r++) begin
                    slot = sched_w[r % BLOCK_WORDS]
                         + sig_lo0(sched_w[(r + 1) % BLOCK_WORDS])
                         + sig_lo1(sched_w[(r + SCHED_TAP_B) % BLOCK_WORDS])
                         + sched_w[(r + SCHED_TAP_A) % BLOCK_WORDS];
                    sched_w[r % BLOCK_WORDS] = slot;
                    step_work_vars(slot, ROUND_K[r]);
                end
                // Fold into the chaining value as it stands now
                for (int k = 0; k < HASH_WORDS; k++) begin
                    chain_h[k] = chain_h[k] + work_v[k];
                    hx.word  = chain_h[k];
                    hx.index = HIDX_W'(k);
                    hx.last  = (k == HASH_WORDS - 1);
                    expected_hash_q.push_back(hx);
                end
            end
        end
    endtask

    task automatic report_mismatch(string field, t_word got, t_word want);
        $display("hash mismatch on %s at %0t: got %h, want %h", field, $time, got, want);
        o_mismatch_count++;
    endtask

    task automatic check_hash_word(t_word got_word, logic [HIDX_W-1:0] got_idx,
                                   logic got_last);
        t_hash_expect hx;
        if (expected_hash_q.size() == 0) begin
            report_mismatch("unexpected hash word", got_word, '0);
        end else begin
            hx = expected_hash_q.pop_front();
            if (got_word !== hx.word)
                report_mismatch("hash_word", got_word, hx.word);
            if (got_idx !== hx.index)
                report_mismatch("hash_index", t_word'(got_idx), t_word'(hx.index));
            if (got_last !== hx.last)
                report_mismatch("last_word", t_word'(got_last), t_word'(hx.last));
        end
    endtask

    // Track every accepted word on both channels
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                chain_h[i] = '0;
                work_v[i]  = '0;
            end
            for (int i = 0; i < BLOCK_WORDS; i++) begin
                sched_w[i] = '0;
            end
            msg_count = 4'd0;
            expected_hash_q.delete();
            o_mismatch_count = 0;
            o_pending_words <= 0;
        end else begin
            if (i_in_ch.valid && i_in_ch.ready)
                absorb_sha_word(i_in_ch.cmd, i_in_ch.data_word, i_in_ch.chain_index);
            if (i_out_ch.valid && i_out_ch.ready)
                check_hash_word(i_out_ch.hash_word, i_out_ch.hash_index, i_out_ch.last_word);
            o_pending_words <= expected_hash_q.size();
        end
    end

endmodule

// File: verif/sha256_block_compress_unit_tb.sv
// Testbench top for the SHA-256 block compression unit: clock, reset, stimulus, verdict.
// Depends on shabc_pkg, both channel interfaces, the unit and sha256_block_compress_checker.
module sha256_block_compress_unit_tb;
    import shabc_pkg::*;

    localparam int RANDOM_WORDS   = 500;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam t_word SHA_IV [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic i_clk;
    logic i_rst_n;
    int   mismatch_count;
    int   pending_words;
    int   idle_cycles;
    bit   tx_idle_on;
    bit   rx_idle_on;
    bit   rx_long_hold;
    int   rand_words;

    shabc_in_if  in_ch ();
    shabc_out_if out_ch ();

    sha256_block_compress_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in_ch  (in_ch),
        .o_out_ch (out_ch)
    );

    sha256_block_compress_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_ch          (in_ch),
        .i_out_ch         (out_ch),
        .o_mismatch_count (mismatch_count),
        .o_pending_words  (pending_words)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offer one input word after a random gap; hold it until ready is seen
    task automatic send_word(logic cmd, t_word data, logic [HIDX_W-1:0] idx);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.cmd         <= cmd;
        in_ch.data_word   <= data;
        in_ch.chain_index <= idx;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Drop valid and wait until every predicted hash word has come out
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_words != 0);
    endtask

    // Mostly full-range words, with all-zero, all-one and one-hot patterns mixed in
    function automatic t_word pick_data();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            2:       return t_word'(1) << $urandom_range(0, WORD_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // One block: chaining loads (full set or a few stray ones), then sixteen message
    // words with the odd load slipped in mid-block
    task automatic run_random_block();
        int n_loads;
        n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : HASH_WORDS;
        for (int i = 0; i < n_loads; i++) begin
            send_word(CMD_LOAD, pick_data(),
                      (n_loads == HASH_WORDS) ? HIDX_W'(i) : HIDX_W'($urandom_range(0, 7)));
            rand_words++;
        end
        for (int w = 0; w < BLOCK_WORDS; w++) begin
            if ($urandom_range(0, 19) == 0) begin
                send_word(CMD_LOAD, pick_data(), HIDX_W'($urandom_range(0, 7)));
                rand_words++;
            end
            send_word(CMD_MSG, pick_data(), HIDX_W'($urandom_range(0, 7)));
            rand_words++;
        end
    endtask

    // Sink side: random stalls per word, one long hold-off on request
    initial begin
        out_ch.ready <= 1'b0;
        rx_idle_on = 1'b1;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            int stall;
            if (rx_long_hold) begin
                stall = LONG_HOLD;
                rx_long_hold = 1'b0;
            end else begin
                stall = rx_idle_on ? $urandom_range(0, 19) : 0;
            end
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
            if (out_ch.last_word)
                rx_idle_on = ($urandom_range(0, 3) != 0);
        end
    end

    // Abort when neither channel moves a word for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Source side: reset, known-answer block, random blocks, verdict
    initial begin
        int blk;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.cmd         <= CMD_LOAD;
        in_ch.data_word   <= '0;
        in_ch.chain_index <= '0;
        tx_idle_on   = 1'b1;
        rx_long_hold = 1'b0;
        rand_words   = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Standard IV, then the padded one-block message "abc"
        for (int i = HASH_WORDS - 1; i >= 0; i--) begin
            send_word(CMD_LOAD, SHA_IV[i], HIDX_W'(i));
        end
        send_word(CMD_MSG, 32'h61626380, '0);
        for (int i = 1; i < BLOCK_WORDS - 1; i++) begin
            send_word(CMD_MSG, '0, '1);
        end
        send_word(CMD_MSG, 32'h00000018, '0);
        wait_for_drain();

        // Random blocks; one long sink hold-off, one full drain partway through
        blk = 0;
        while (rand_words < RANDOM_WORDS) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            if (blk == 2)
                rx_long_hold = 1'b1;
            if (blk == 5)
                wait_for_drain();
            run_random_block();
            blk++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/shabc_pkg.sv
src/shabc_in_if.sv
src/shabc_out_if.sv
src/shabc_round.sv
src/shabc_sched.sv
src/shabc_ctrl.sv
src/sha256_block_compress_unit.sv
verif/sha256_block_compress_checker.sv
verif/sha256_block_compress_unit_tb.sv
